// File: rtl/pwrr_pkg.sv
package pwrr_pkg;

  localparam int MAX_QUEUES  = 8;
  localparam int WEIGHT_BITS = 8;

  localparam int QIDX_BITS  = $clog2(MAX_QUEUES);
  localparam int QCNT_BITS  = 4;
  localparam int WEIGHTS_W  = 56;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 56;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  localparam logic [QCNT_BITS-1:0] QUEUES_RESET  = QCNT_BITS'(MAX_QUEUES);
  localparam logic [WEIGHTS_W-1:0] WEIGHTS_RESET = 56'h01010101010101;

  localparam logic [CFG_IDX_W-1:0] REG_QUEUES_IN_USE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_PACKED = 4'd1;

  typedef logic [MAX_QUEUES-1:0][WEIGHT_BITS-1:0] token_vec_t;

  typedef struct packed {
    logic                 grant_valid;
    logic [QIDX_BITS-1:0] grant_queue;
    logic                 tokens_reloaded;
    logic                 weight_starved;
  } result_t;

  // weight of queue q, zero for queue 0 and for bits beyond the register
  function automatic logic [WEIGHT_BITS-1:0] weight_of(
    input logic [WEIGHTS_W-1:0] weights,
    input int                   q
  );
    logic [WEIGHT_BITS-1:0] r;
    int                     idx;
    r = '0;
    for (int b = 0; b < WEIGHT_BITS; b++) begin
      idx = (q - 1) * WEIGHT_BITS + b;
      if (q >= 1 && idx < WEIGHTS_W) begin
        r[b] = weights[idx];
      end
    end
    return r;
  endfunction

  function automatic token_vec_t all_weights(input logic [WEIGHTS_W-1:0] weights);
    token_vec_t t;
    for (int q = 0; q < MAX_QUEUES; q++) begin
      t[q] = weight_of(weights, q);
    end
    return t;
  endfunction

endpackage

// File: rtl/pwrr_decide.sv
module pwrr_decide (
  input  logic [pwrr_pkg::MAX_QUEUES-1:0]  nonempty_mask,
  input  logic [pwrr_pkg::QCNT_BITS-1:0]   queues_in_use,
  input  logic [pwrr_pkg::WEIGHTS_W-1:0]   weights_packed,
  input  pwrr_pkg::token_vec_t             tokens,
  output pwrr_pkg::result_t                result,
  output pwrr_pkg::token_vec_t             tokens_next
);

  logic [pwrr_pkg::QCNT_BITS-1:0]  n_eff;
  logic [pwrr_pkg::MAX_QUEUES-1:0] mask;
  logic [pwrr_pkg::MAX_QUEUES-1:0] hit_first;
  logic [pwrr_pkg::MAX_QUEUES-1:0] hit_reload;
  logic [pwrr_pkg::QIDX_BITS-1:0]  idx_first;
  logic [pwrr_pkg::QIDX_BITS-1:0]  idx_reload;
  logic                            found_first;
  logic                            found_reload;
  pwrr_pkg::token_vec_t            reload_val;

  // clamp queue count into 1..MAX_QUEUES
  always_comb begin
    if (queues_in_use == '0) begin
      n_eff = pwrr_pkg::QCNT_BITS'(1);
    end else if (queues_in_use > pwrr_pkg::QCNT_BITS'(pwrr_pkg::MAX_QUEUES)) begin
      n_eff = pwrr_pkg::QCNT_BITS'(pwrr_pkg::MAX_QUEUES);
    end else begin
      n_eff = queues_in_use;
    end
  end

  assign reload_val = pwrr_pkg::all_weights(weights_packed);

  always_comb begin
    for (int q = 0; q < pwrr_pkg::MAX_QUEUES; q++) begin
      mask[q] = nonempty_mask[q] && (pwrr_pkg::QCNT_BITS'(q) < n_eff);
    end
    hit_first  = '0;
    hit_reload = '0;
    for (int q = 1; q < pwrr_pkg::MAX_QUEUES; q++) begin
      hit_first[q]  = mask[q] && (tokens[q] != '0);
      hit_reload[q] = mask[q] && (reload_val[q] != '0);
    end
  end

  // lowest set bit, two encoders in parallel
  always_comb begin
    found_first  = 1'b0;
    found_reload = 1'b0;
    idx_first    = '0;
    idx_reload   = '0;
    for (int q = pwrr_pkg::MAX_QUEUES - 1; q >= 1; q--) begin
      if (hit_first[q]) begin
        found_first = 1'b1;
        idx_first   = pwrr_pkg::QIDX_BITS'(q);
      end
      if (hit_reload[q]) begin
        found_reload = 1'b1;
        idx_reload   = pwrr_pkg::QIDX_BITS'(q);
      end
    end
  end

  always_comb begin
    result      = '0;
    tokens_next = tokens;
    if (mask[0]) begin
      result.grant_valid = 1'b1;
    end else if (mask != '0) begin
      if (found_first) begin
        result.grant_valid     = 1'b1;
        result.grant_queue     = idx_first;
        tokens_next[idx_first] = tokens[idx_first] - pwrr_pkg::WEIGHT_BITS'(1);
      end else begin
        result.tokens_reloaded = 1'b1;
        tokens_next            = reload_val;
        if (found_reload) begin
          result.grant_valid      = 1'b1;
          result.grant_queue      = idx_reload;
          tokens_next[idx_reload] = reload_val[idx_reload] - pwrr_pkg::WEIGHT_BITS'(1);
        end else begin
          result.weight_starved = 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/priority_wrr_queue_scheduler.sv
// an accepted item waits in the input register until the result register is free, then
// its result is written there; the decision and the token update commit together
// throughput: one item per cycle while m_tready is held high
// reset (rst, synchronous): queue count 8, all weights 1, token counts loaded from
// those weights, both pipeline registers empty
module priority_wrr_queue_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwrr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwrr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pwrr_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] nonempty_mask
  // grant items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pwrr_pkg::OUT_DATA_W-1:0]   m_tdata    // [0] grant_valid, [3:1] grant_queue,
                                                       // [4] tokens_reloaded,
                                                       // [5] weight_starved, [7:6] zero
);

  // configuration registers
  logic [pwrr_pkg::QCNT_BITS-1:0] queues_in_use;
  logic [pwrr_pkg::WEIGHTS_W-1:0] weights_packed;

  // token counts, entry 0 stays at zero
  pwrr_pkg::token_vec_t tokens;
  pwrr_pkg::token_vec_t tokens_next;

  // input register
  logic                            in_valid;
  logic [pwrr_pkg::MAX_QUEUES-1:0] in_mask;

  // result register
  logic              out_valid;
  pwrr_pkg::result_t out_result;
  pwrr_pkg::result_t result;

  logic out_free;
  logic decide;

  // writes always land at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      queues_in_use  <= pwrr_pkg::QUEUES_RESET;
      weights_packed <= pwrr_pkg::WEIGHTS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pwrr_pkg::REG_QUEUES_IN_USE:  queues_in_use  <= cfg_data[pwrr_pkg::QCNT_BITS-1:0];
        pwrr_pkg::REG_WEIGHTS_PACKED: weights_packed <= cfg_data[pwrr_pkg::WEIGHTS_W-1:0];
        default: ;
      endcase
    end
  end

  // result register drains when taken; decision stage fires into a free slot
  assign out_free = !out_valid || m_tready;
  assign decide   = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mask <= s_tdata[pwrr_pkg::MAX_QUEUES-1:0];
    end
  end

  pwrr_decide u_decide (
    .nonempty_mask  (in_mask),
    .queues_in_use  (queues_in_use),
    .weights_packed (weights_packed),
    .tokens         (tokens),
    .result         (result),
    .tokens_next    (tokens_next)
  );

  // token state moves only when a decision is committed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tokens <= pwrr_pkg::all_weights(pwrr_pkg::WEIGHTS_RESET);
    end else if (decide) begin
      tokens <= tokens_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_result.weight_starved, out_result.tokens_reloaded,
                     out_result.grant_queue, out_result.grant_valid};

endmodule
